[sv/gsn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package gsn_pkg;
    localparam int NORM_W  = 16;
    localparam int FRAC_OUT = 14;
    localparam int ONE_OUT = 16384;

    typedef struct packed {
        logic signed [NORM_W-1:0] x;
        logic signed [NORM_W-1:0] y;
        logic signed [NORM_W-1:0] z;
    } norm_t;
endpackage
`default_nettype wire

[sv/gsn_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module gsn_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[sv/gsn_norm.sv]
`timescale 1ns / 1ps
`default_nettype none
// Cross product and normalization: multicycle, one square-root or divide bit per cycle.
module gsn_norm
    import gsn_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic signed [COORD_BITS-1:0] p_x, p_y, p_z,
    input  wire logic signed [COORD_BITS-1:0] u_x, u_y, u_z,
    input  wire logic signed [COORD_BITS-1:0] r_x, r_y, r_z,
    output logic                              done,
    output norm_t                             n
);
    localparam int DW = COORD_BITS + 1;
    localparam int DS = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
    localparam int EW = DW - DS;
    localparam int PW = 2 * EW + 1;
    localparam int MW = 31;
    localparam int SW = 64;
    localparam int QW = MW + FRAC_OUT + 1;
    localparam int SHW = $clog2(PW + 2) + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_MUL1, S_MUL2, S_MAG, S_SHIFT, S_SQ, S_SQRT, S_DIV, S_OUT
    } state_t;

    state_t state_reg;
    logic signed [EW-1:0] ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [PW-1:0] a_reg [3];
    logic signed [PW-1:0] b_reg [3];
    logic [2:0] sgn_reg;
    logic [PW-1:0] mag_reg [3];
    logic [MW-1:0] m_reg [3];
    logic [SW-1:0] sum_reg, rem_reg, root_reg, bit_reg;
    logic [1:0] idx_reg;
    logic [QW-1:0] quo_reg, dr_reg;
    logic [SW-1:0] den_reg;
    logic [6:0] cnt_reg;
    logic [SHW-1:0] lz_reg;
    norm_t n_reg;
    logic zero_reg;

    function automatic logic signed [EW-1:0] dsub(input logic signed [COORD_BITS-1:0] a,
                                                   input logic signed [COORD_BITS-1:0] b);
        logic signed [DW-1:0] d;
        logic [DW-1:0] m;
        d = DW'(a) - DW'(b);
        m = d[DW-1] ? DW'(-d) : DW'(d);
        m = m >> DS;
        return d[DW-1] ? -EW'(m) : EW'(m);
    endfunction

    logic [PW-1:0] mx;
    logic [PW-1:0] mag_c [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_c[i] = a_reg[i][PW-1] ? PW'(-a_reg[i]) : PW'(a_reg[i]);
        end
        mx = mag_reg[0];
        if (mag_reg[1] > mx) mx = mag_reg[1];
        if (mag_reg[2] > mx) mx = mag_reg[2];
    end

    // position of the leading one of mx
    logic [SHW-1:0] msb;
    always_comb
    begin
        msb = '0;
        for (int i = 0; i < PW; i++)
        begin
            if (mx[i]) msb = SHW'(i);
        end
    end

    assign done = (state_reg == S_OUT);
    assign n = n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        ux_reg <= dsub(p_x, u_x); uy_reg <= dsub(p_y, u_y);
                        uz_reg <= dsub(p_z, u_z);
                        vx_reg <= dsub(r_x, u_x); vy_reg <= dsub(r_y, u_y);
                        vz_reg <= dsub(r_z, u_z);
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    a_reg[0] <= PW'(uy_reg) * PW'(vz_reg); b_reg[0] <= PW'(uz_reg) * PW'(vy_reg);
                    a_reg[1] <= PW'(uz_reg) * PW'(vx_reg); b_reg[1] <= PW'(ux_reg) * PW'(vz_reg);
                    a_reg[2] <= PW'(ux_reg) * PW'(vy_reg); b_reg[2] <= PW'(uy_reg) * PW'(vx_reg);
                    state_reg <= S_MUL1;
                end
                S_MUL1:
                begin
                    for (int i = 0; i < 3; i++) a_reg[i] <= a_reg[i] - b_reg[i];
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_c[i];
                        sgn_reg[i] <= a_reg[i][PW-1];
                    end
                    state_reg <= S_MAG;
                end
                S_MAG:
                begin
                    zero_reg <= (mx == '0);
                    lz_reg <= msb;
                    state_reg <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (lz_reg >= SHW'(29))
                            m_reg[i] <= MW'(mag_reg[i] >> (lz_reg - SHW'(29)));
                        else
                            m_reg[i] <= MW'({{(MW){1'b0}}, mag_reg[i]} << (SHW'(29) - lz_reg));
                    end
                    idx_reg <= '0;
                    sum_reg <= '0;
                    state_reg <= zero_reg ? S_OUT : S_SQ;
                    if (zero_reg) n_reg <= '0;
                end
                S_SQ:
                begin
                    sum_reg <= sum_reg + SW'(m_reg[idx_reg]) * SW'(m_reg[idx_reg]);
                    if (idx_reg == 2'd2)
                    begin
                        root_reg <= '0;
                        bit_reg <= SW'(1) << 62;
                        state_reg <= S_SQRT;
                    end
                    idx_reg <= idx_reg + 2'd1;
                end
                S_SQRT:
                begin
                    if (bit_reg == '0)
                    begin
                        den_reg <= root_reg;
                        idx_reg <= '0;
                        cnt_reg <= 7'(QW);
                        quo_reg <= '0;
                        dr_reg <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        if (sum_reg >= root_reg + bit_reg)
                        begin
                            sum_reg <= sum_reg - (root_reg + bit_reg);
                            root_reg <= (root_reg >> 1) + bit_reg;
                        end
                        else
                        begin
                            root_reg <= root_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                S_DIV:
                begin
                    if (cnt_reg == 7'(QW))
                    begin
                        rem_reg <= '0;
                        dr_reg <= QW'({m_reg[idx_reg], {FRAC_OUT{1'b0}}}) + QW'(den_reg >> 1);
                        cnt_reg <= cnt_reg - 7'd1;
                        quo_reg <= '0;
                    end
                    else if (cnt_reg != '1)
                    begin
                        logic [SW-1:0] t;
                        t = {rem_reg[SW-2:0], dr_reg[QW-1]};
                        dr_reg <= dr_reg << 1;
                        if (t >= den_reg)
                        begin
                            rem_reg <= t - den_reg;
                            quo_reg <= {quo_reg[QW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= t;
                            quo_reg <= {quo_reg[QW-2:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg - 7'd1;
                    end
                    else
                    begin
                        logic [NORM_W-1:0] q;
                        q = (quo_reg > QW'(ONE_OUT)) ? NORM_W'(ONE_OUT) : NORM_W'(quo_reg);
                        if (sgn_reg[idx_reg]) q = -q;
                        unique case (idx_reg)
                            2'd0: n_reg.x <= q;
                            2'd1: n_reg.y <= q;
                            default: n_reg.z <= q;
                        endcase
                        cnt_reg <= 7'(QW);
                        idx_reg <= idx_reg + 2'd1;
                        if (idx_reg == 2'd2) state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[sv/grid_surface_normals_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Grid surface normals.
// Input channel (in_valid/in_ready, px/py/pz) takes grid points in row-major order.
// Output channel (out_valid/out_ready) gives unit normals nx/ny/nz with row, col, last.
// Config channel (cfg_valid/cfg_ready, cfg_data) writes grid_size and restarts the grid;
// write it only while the block is idle. in_ready is low while cfg_valid is high.
// One point is handled at a time. A row 0 point is accepted and emits nothing. A point
// that needs a normal goes through the point store reads, the normalizer (bit-serial
// square root and three bit-serial divides), then emit and write-back. A zero-length
// normal skips the square root and divides. The last column copy goes straight to emit
// and write-back.
// The final point of the grid then drains the last row from the first-row store, one
// normal at a time, pausing while the receiver stalls.
// A single output register holds each normal; when the receiver stalls, the block
// waits with it and in_ready stays low. Reset sets grid_size to 20 and the position to
// row 0, column 0. The point and normal stores are not cleared; they are written before
// being read.
module grid_surface_normals_unit
    import gsn_pkg::*;
#(
    parameter int MAX_GRID = 32,
    parameter int COORD_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic signed [15:0]     px,
    input  wire logic signed [15:0]     py,
    input  wire logic signed [15:0]     pz,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic signed [15:0]          nx,
    output logic signed [15:0]          ny,
    output logic signed [15:0]          nz,
    output logic [4:0]                  row,
    output logic [4:0]                  col,
    output logic                        last,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [5:0]             cfg_data
);
    localparam int AW = $clog2(MAX_GRID);
    localparam int CW = AW + 1;
    localparam int PTW = 3 * COORD_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_RD1, S_RD2, S_CALC, S_WAITN, S_EMIT, S_WR, S_DRAIN_RD, S_DRAIN_WT
    } state_t;

    state_t state_reg;
    logic [5:0] gsize_reg;
    logic [CW-1:0] row_reg, col_reg, jdx_reg;
    norm_t rsn_reg, n_hold_reg;
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg, cz_reg;
    logic [PTW-1:0] up_reg;

    logic [CW-1:0] g;
    always_comb
    begin
        if (gsize_reg < 6'd2) g = CW'(2);
        else if (32'(gsize_reg) > MAX_GRID) g = CW'(MAX_GRID);
        else g = CW'(gsize_reg);
    end

    logic pt_we;
    logic [AW-1:0] pt_ra, nr_ra;
    logic [PTW-1:0] pt_rd;
    logic nr_we;
    logic [3*NORM_W-1:0] nr_rd;

    gsn_ram #(.WIDTH(PTW), .DEPTH(MAX_GRID)) u_pts (
        .clk(clk), .we(pt_we), .waddr(col_reg[AW-1:0]),
        .wdata({cx_reg, cy_reg, cz_reg}), .raddr(pt_ra), .rdata(pt_rd)
    );

    gsn_ram #(.WIDTH(3*NORM_W), .DEPTH(MAX_GRID)) u_nrm (
        .clk(clk), .we(nr_we), .waddr(col_reg[AW-1:0]),
        .wdata(n_hold_reg), .raddr(nr_ra), .rdata(nr_rd)
    );

    logic nstart, ndone;
    norm_t nres;

    gsn_norm #(.COORD_BITS(COORD_BITS)) u_norm (
        .clk(clk), .rst_n(rst_n), .start(nstart),
        .p_x(cx_reg), .p_y(cy_reg), .p_z(cz_reg),
        .u_x(up_reg[3*COORD_BITS-1:2*COORD_BITS]),
        .u_y(up_reg[2*COORD_BITS-1:COORD_BITS]),
        .u_z(up_reg[COORD_BITS-1:0]),
        .r_x(pt_rd[3*COORD_BITS-1:2*COORD_BITS]),
        .r_y(pt_rd[2*COORD_BITS-1:COORD_BITS]),
        .r_z(pt_rd[COORD_BITS-1:0]),
        .done(ndone), .n(nres)
    );

    assign in_ready = (state_reg == S_IDLE) && !out_valid && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE) && !out_valid;
    assign pt_we = (state_reg == S_WR);
    assign nr_we = (state_reg == S_WR) && (row_reg == CW'(1));
    assign nstart = (state_reg == S_CALC);
    assign pt_ra = (state_reg == S_IDLE) ? col_reg[AW-1:0] : AW'(col_reg + CW'(1));
    assign nr_ra = jdx_reg[AW-1:0];

    logic [CW-1:0] col_n, row_n;
    always_comb
    begin
        col_n = col_reg + CW'(1);
        row_n = row_reg;
        if (col_n == g)
        begin
            col_n = '0;
            row_n = row_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            gsize_reg <= 6'd20;
            row_reg <= '0;
            col_reg <= '0;
            jdx_reg <= '0;
            rsn_reg <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready) out_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid && cfg_ready)
                    begin
                        gsize_reg <= cfg_data;
                        row_reg <= '0;
                        col_reg <= '0;
                    end
                    else if (in_valid && in_ready)
                    begin
                        cx_reg <= COORD_BITS'($unsigned(px));
                        cy_reg <= COORD_BITS'($unsigned(py));
                        cz_reg <= COORD_BITS'($unsigned(pz));
                        if (row_reg >= g || col_reg >= g)
                        begin
                            row_reg <= '0;
                            col_reg <= '0;
                            state_reg <= S_WR;
                        end
                        else if (row_reg == '0) state_reg <= S_WR;
                        else if (col_reg == g - CW'(1))
                        begin
                            n_hold_reg <= rsn_reg;
                            state_reg <= S_EMIT;
                        end
                        else state_reg <= S_RD1;
                    end
                end
                S_RD1:
                begin
                    up_reg <= pt_rd;
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    state_reg <= S_WAITN;
                end
                S_WAITN:
                begin
                    if (ndone)
                    begin
                        n_hold_reg <= nres;
                        if (col_reg == '0) rsn_reg <= nres;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    nx <= n_hold_reg.x; ny <= n_hold_reg.y; nz <= n_hold_reg.z;
                    row <= 5'(row_reg - CW'(1));
                    col <= 5'(col_reg);
                    last <= 1'b0;
                    out_valid <= 1'b1;
                    state_reg <= S_WR;
                end
                S_WR:
                begin
                    col_reg <= col_n;
                    row_reg <= row_n;
                    jdx_reg <= '0;
                    if (col_n == '0 && row_n == g)
                    begin
                        row_reg <= '0;
                        state_reg <= S_DRAIN_RD;
                    end
                    else state_reg <= S_IDLE;
                end
                S_DRAIN_RD:
                begin
                    if (!out_valid || out_ready) state_reg <= S_DRAIN_WT;
                end
                S_DRAIN_WT:
                begin
                    if (!out_valid || out_ready)
                    begin
                        nx <= nr_rd[3*NORM_W-1:2*NORM_W];
                        ny <= nr_rd[2*NORM_W-1:NORM_W];
                        nz <= nr_rd[NORM_W-1:0];
                        row <= 5'(g - CW'(1));
                        col <= 5'(jdx_reg);
                        last <= (jdx_reg == g - CW'(1));
                        out_valid <= 1'b1;
                        jdx_reg <= jdx_reg + CW'(1);
                        state_reg <= (jdx_reg == g - CW'(1)) ? S_IDLE : S_DRAIN_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[sv/gsn_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module gsn_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [15:0] nx,
    input wire logic [15:0] ny,
    input wire logic [15:0] nz,
    input wire logic       cfg_ready
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(nx) && $stable(ny) && $stable(nz))
        else $error("output request dropped while stalled");
    a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while output pending");
    a_cfg_with_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> cfg_ready)
        else $error("input ready without config ready");
    a_nx_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(nx) <= 16'sd16384 && $signed(nx) >= -16'sd16384))
        else $error("nx out of range");
endmodule

bind grid_surface_normals_unit gsn_checker u_gsn_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .nx(nx), .ny(ny), .nz(nz),
    .cfg_ready(cfg_ready)
);
`default_nettype wire
